@@ rtl/core/bfid_pkg.sv @@
// ----------------------------------------------------------------------------
// bfid_pkg
// Shared types, constants and helpers of the box filter downscaler.
// ----------------------------------------------------------------------------
`default_nettype none

package bfid_pkg;

  localparam int MAX_SIDE  = 4096;
  localparam int SIDE_W    = $clog2(MAX_SIDE) + 1;   // holds MAX_SIDE itself
  localparam int COL_W     = $clog2(MAX_SIDE);       // holds MAX_SIDE-1
  localparam int SUM_W     = 32;
  localparam int DIVD_W    = 32;
  localparam int DIVS_W    = 2 * COL_W + 1;
  localparam int CNT_W     = $clog2(DIVD_W);
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_W   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_H   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIM = 2'd2;

  typedef enum logic [3:0] {
    ST_RESTART,
    ST_CLEAR,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_IDLE,
    ST_READ,
    ST_ACC,
    ST_EMIT,
    ST_ADVANCE
  } state_t;

  typedef enum logic [3:0] {
    DSEL_DW,
    DSEL_DH,
    DSEL_X0,
    DSEL_X1,
    DSEL_Y0,
    DSEL_Y1,
    DSEL_RED,
    DSEL_GREEN,
    DSEL_BLUE,
    DSEL_ALPHA
  } dsel_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_RESTART,
    OP_CLR_STEP,
    OP_DIV_START,
    OP_DIV_STORE,
    OP_ACCEPT,
    OP_READ,
    OP_ACC,
    OP_EMIT,
    OP_ADVANCE
  } op_t;

  typedef struct packed {
    op_t   op;
    dsel_t sel;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic need_scale;
    logic div_done;
    logic emit_hit;
    logic out_free;
  } dp_sts_t;

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [CFG_DAT_W-1:0] v);
    logic [SIDE_W-1:0] r;
    if (v == '0) begin
      r = SIDE_W'(1);
    end else if (SIDE_W'(v) > SIDE_W'(MAX_SIDE)) begin
      r = SIDE_W'(MAX_SIDE);
    end else begin
      r = SIDE_W'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/bfid_div.sv @@
// ----------------------------------------------------------------------------
// bfid_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bfid_div
  import bfid_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DIVD_W-1:0] dividend,
  input  wire logic [DIVS_W-1:0] divisor,
  output logic                   done,
  output logic      [DIVD_W-1:0] quotient
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIVS_W:0]   rem_r, rem_nxt;
  logic [DIVD_W-1:0] quo_r, quo_nxt;
  logic [DIVS_W-1:0] dvs_r, dvs_nxt;
  logic [DIVS_W:0]   rem_sh;
  logic              ge;

  assign rem_sh = {rem_r[DIVS_W-1:0], quo_r[DIVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '1;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? rem_sh - {1'b0, dvs_r} : rem_sh;
      quo_nxt = {quo_r[DIVD_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

@@ rtl/core/bfid_dp.sv @@
// ----------------------------------------------------------------------------
// bfid_dp
// Datapath: registers, position counters, column sum memory, divider,
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bfid_dp
  import bfid_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_write_enable,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_write_data,
  input  wire logic [31:0]          in_source_pixel,
  input  wire dp_cmd_t              cmd,
  output dp_sts_t                   sts,
  input  wire logic                 out_stall,
  output logic                      out_valid,
  output logic      [7:0]           out_red,
  output logic      [7:0]           out_green,
  output logic      [7:0]           out_blue,
  output logic      [7:0]           out_alpha,
  output logic      [COL_W-1:0]     out_dest_x,
  output logic      [COL_W-1:0]     out_dest_y,
  output logic                      out_frame_last
);

  logic [CFG_DAT_W-1:0] sw_r, sh_r, md_r;
  logic [SIDE_W-1:0]    eff_w_r, eff_h_r, dw_r, dh_r;
  logic [SIDE_W-1:0]    x0_r, x1_r, y0_r, y1_r;
  logic [COL_W-1:0]     src_col_r, src_row_r, dst_col_r, dst_row_r;
  logic [COL_W-1:0]     clr_addr_r;
  logic [31:0]          pix_r;
  logic [DIVS_W-1:0]    n_r;
  logic [7:0]           mr_r, mg_r, mb_r, ma_r;
  logic [4*SUM_W-1:0]   rd_q_r, sum_r;
  logic [4*SUM_W-1:0]   mem [MAX_SIDE];

  logic                 out_valid_r;
  logic [7:0]           o_r_r, o_g_r, o_b_r, o_a_r;
  logic [COL_W-1:0]     o_x_r, o_y_r;
  logic                 o_last_r;

  logic [SIDE_W-1:0]    larger;
  logic [SIDE_W-1:0]    col_p1, row_p1, scol_p1, srow_p1, dcol_p1, drow_p1;
  logic [SIDE_W-1:0]    mul_a, mul_b;
  logic [2*SIDE_W-1:0]  prod, n_prod;
  logic [DIVD_W-1:0]    dividend;
  logic [DIVS_W-1:0]    divisor;
  logic                 div_done;
  logic [DIVD_W-1:0]    quotient;
  logic [SIDE_W-1:0]    q_side;
  logic [4*SUM_W-1:0]   sum_nxt;
  logic                 last_col, last_row, emit_hit;
  logic                 mem_we;
  logic [COL_W-1:0]     mem_addr;
  logic [4*SUM_W-1:0]   mem_wdata;

  assign larger  = (eff_w_r > eff_h_r) ? eff_w_r : eff_h_r;
  assign dcol_p1 = {1'b0, dst_col_r} + SIDE_W'(1);
  assign drow_p1 = {1'b0, dst_row_r} + SIDE_W'(1);
  assign scol_p1 = {1'b0, src_col_r} + SIDE_W'(1);
  assign srow_p1 = {1'b0, src_row_r} + SIDE_W'(1);
  assign col_p1  = dcol_p1;
  assign row_p1  = drow_p1;

  assign last_col = scol_p1 == x1_r;
  assign last_row = srow_p1 == y1_r;
  assign emit_hit = last_col && last_row;

  // operand selection for the divider
  always_comb begin
    mul_a    = eff_w_r;
    mul_b    = SIDE_W'(md_r);
    divisor  = DIVS_W'(larger);
    dividend = '0;
    case (cmd.sel)
      DSEL_DW: begin
        mul_a = eff_w_r; mul_b = SIDE_W'(md_r); divisor = DIVS_W'(larger);
      end
      DSEL_DH: begin
        mul_a = eff_h_r; mul_b = SIDE_W'(md_r); divisor = DIVS_W'(larger);
      end
      DSEL_X0: begin
        mul_a = {1'b0, dst_col_r}; mul_b = eff_w_r; divisor = DIVS_W'(dw_r);
      end
      DSEL_X1: begin
        mul_a = col_p1; mul_b = eff_w_r; divisor = DIVS_W'(dw_r);
      end
      DSEL_Y0: begin
        mul_a = {1'b0, dst_row_r}; mul_b = eff_h_r; divisor = DIVS_W'(dh_r);
      end
      DSEL_Y1: begin
        mul_a = row_p1; mul_b = eff_h_r; divisor = DIVS_W'(dh_r);
      end
      default: begin
        divisor = n_r;
      end
    endcase
    prod = mul_a * mul_b;
    case (cmd.sel)
      DSEL_RED:   dividend = sum_r[2*SUM_W +: SUM_W];
      DSEL_GREEN: dividend = sum_r[1*SUM_W +: SUM_W];
      DSEL_BLUE:  dividend = sum_r[0*SUM_W +: SUM_W];
      DSEL_ALPHA: dividend = sum_r[3*SUM_W +: SUM_W];
      default:    dividend = DIVD_W'(prod);
    endcase
  end

  bfid_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.op == OP_DIV_START),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  assign q_side = (quotient == '0) ? SIDE_W'(1) : quotient[SIDE_W-1:0];

  // channel order in memory word: alpha, red, green, blue
  assign sum_nxt = {rd_q_r[3*SUM_W +: SUM_W] + SUM_W'(pix_r[31:24]),
                    rd_q_r[2*SUM_W +: SUM_W] + SUM_W'(pix_r[23:16]),
                    rd_q_r[1*SUM_W +: SUM_W] + SUM_W'(pix_r[15:8]),
                    rd_q_r[0*SUM_W +: SUM_W] + SUM_W'(pix_r[7:0])};

  assign n_prod = (x1_r - x0_r) * (y1_r - y0_r);

  assign mem_we    = (cmd.op == OP_CLR_STEP) || (cmd.op == OP_ACC);
  assign mem_addr  = (cmd.op == OP_CLR_STEP) ? clr_addr_r : dst_col_r;
  assign mem_wdata = ((cmd.op == OP_CLR_STEP) || emit_hit) ? '0 : sum_nxt;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (cmd.op == OP_READ) begin
      rd_q_r <= mem[dst_col_r];
    end
  end

  // configuration, frame geometry and positions
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r       <= CFG_DAT_W'(1);
      sh_r       <= CFG_DAT_W'(1);
      md_r       <= '0;
      eff_w_r    <= SIDE_W'(1);
      eff_h_r    <= SIDE_W'(1);
      dw_r       <= SIDE_W'(1);
      dh_r       <= SIDE_W'(1);
      src_col_r  <= '0;
      src_row_r  <= '0;
      dst_col_r  <= '0;
      dst_row_r  <= '0;
      clr_addr_r <= '0;
    end else begin
      if (cfg_write_enable) begin
        case (cfg_index)
          REG_SRC_W:   sw_r <= cfg_write_data;
          REG_SRC_H:   sh_r <= cfg_write_data;
          REG_MAX_DIM: md_r <= cfg_write_data;
          default:     ;
        endcase
      end
      case (cmd.op)
        OP_RESTART: begin
          eff_w_r    <= clamp_side(sw_r);
          eff_h_r    <= clamp_side(sh_r);
          dw_r       <= clamp_side(sw_r);
          dh_r       <= clamp_side(sh_r);
          src_col_r  <= '0;
          src_row_r  <= '0;
          dst_col_r  <= '0;
          dst_row_r  <= '0;
          clr_addr_r <= '0;
        end
        OP_CLR_STEP: clr_addr_r <= clr_addr_r + COL_W'(1);
        OP_DIV_STORE: begin
          case (cmd.sel)
            DSEL_DW: dw_r <= q_side;
            DSEL_DH: dh_r <= q_side;
            default: ;
          endcase
        end
        OP_ADVANCE: begin
          if (scol_p1 >= eff_w_r) begin
            src_col_r <= '0;
            dst_col_r <= '0;
            if (srow_p1 >= eff_h_r) begin
              src_row_r <= '0;
              dst_row_r <= '0;
            end else begin
              src_row_r <= srow_p1[COL_W-1:0];
              if (last_row) begin
                dst_row_r <= drow_p1[COL_W-1:0];
              end
            end
          end else begin
            src_col_r <= scol_p1[COL_W-1:0];
            if (last_col) begin
              dst_col_r <= dcol_p1[COL_W-1:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.op == OP_ACCEPT) begin
      pix_r <= in_source_pixel;
    end
    if (cmd.op == OP_ACC) begin
      sum_r <= sum_nxt;
      n_r   <= (n_prod == '0) ? DIVS_W'(1) : n_prod[DIVS_W-1:0];
    end
    if (cmd.op == OP_DIV_STORE) begin
      case (cmd.sel)
        DSEL_X0:    x0_r <= quotient[SIDE_W-1:0];
        DSEL_X1:    x1_r <= quotient[SIDE_W-1:0];
        DSEL_Y0:    y0_r <= quotient[SIDE_W-1:0];
        DSEL_Y1:    y1_r <= quotient[SIDE_W-1:0];
        DSEL_RED:   mr_r <= quotient[7:0];
        DSEL_GREEN: mg_r <= quotient[7:0];
        DSEL_BLUE:  mb_r <= quotient[7:0];
        DSEL_ALPHA: ma_r <= quotient[7:0];
        default:    ;
      endcase
    end
    if (cmd.op == OP_EMIT) begin
      o_r_r    <= mr_r;
      o_g_r    <= mg_r;
      o_b_r    <= mb_r;
      o_a_r    <= ma_r;
      o_x_r    <= dst_col_r;
      o_y_r    <= dst_row_r;
      o_last_r <= (dcol_p1 == dw_r) && (drow_p1 == dh_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.clr_done   = clr_addr_r == COL_W'(MAX_SIDE - 1);
  assign sts.need_scale = (md_r != '0) &&
                          ((eff_w_r > SIDE_W'(md_r)) || (eff_h_r > SIDE_W'(md_r)));
  assign sts.div_done   = div_done;
  assign sts.emit_hit   = emit_hit;
  assign sts.out_free   = !out_valid_r || !out_stall;

  assign out_valid      = out_valid_r;
  assign out_red        = o_r_r;
  assign out_green      = o_g_r;
  assign out_blue       = o_b_r;
  assign out_alpha      = o_a_r;
  assign out_dest_x     = o_x_r;
  assign out_dest_y     = o_y_r;
  assign out_frame_last = o_last_r;

endmodule

`default_nettype wire

@@ rtl/core/bfid_ctrl.sv @@
// ----------------------------------------------------------------------------
// bfid_ctrl
// Sequencer: frame restart, clear, size/bound/mean divisions, accumulate, emit.
// ----------------------------------------------------------------------------
`default_nettype none

module bfid_ctrl
  import bfid_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    cfg_hit,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  state_t state_r, state_nxt;
  dsel_t  sel_r, sel_nxt;

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    case (state_r)
      ST_RESTART: state_nxt = ST_CLEAR;
      ST_CLEAR: begin
        if (sts.clr_done) begin
          if (sts.need_scale) begin
            state_nxt = ST_DIV_GO;
            sel_nxt   = DSEL_DW;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_DIV_GO: state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (sts.div_done) begin
          state_nxt = ST_DIV_GO;
          case (sel_r)
            DSEL_DW:    sel_nxt = DSEL_DH;
            DSEL_DH:    state_nxt = ST_IDLE;
            DSEL_X0:    sel_nxt = DSEL_X1;
            DSEL_X1:    sel_nxt = DSEL_Y0;
            DSEL_Y0:    sel_nxt = DSEL_Y1;
            DSEL_Y1:    state_nxt = ST_READ;
            DSEL_RED:   sel_nxt = DSEL_GREEN;
            DSEL_GREEN: sel_nxt = DSEL_BLUE;
            DSEL_BLUE:  sel_nxt = DSEL_ALPHA;
            DSEL_ALPHA: state_nxt = ST_EMIT;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DIV_GO;
          sel_nxt   = DSEL_X0;
        end
      end
      ST_READ: state_nxt = ST_ACC;
      ST_ACC: begin
        if (sts.emit_hit) begin
          state_nxt = ST_DIV_GO;
          sel_nxt   = DSEL_RED;
        end else begin
          state_nxt = ST_ADVANCE;
        end
      end
      ST_EMIT:    if (sts.out_free) state_nxt = ST_ADVANCE;
      ST_ADVANCE: state_nxt = ST_IDLE;
      default:    state_nxt = ST_RESTART;
    endcase
    if (cfg_hit) begin
      state_nxt = ST_RESTART;
    end
  end

  always_comb begin
    cmd.op  = OP_NONE;
    cmd.sel = sel_r;
    case (state_r)
      ST_RESTART:  cmd.op = OP_RESTART;
      ST_CLEAR:    cmd.op = OP_CLR_STEP;
      ST_DIV_GO:   cmd.op = OP_DIV_START;
      ST_DIV_WAIT: cmd.op = sts.div_done ? OP_DIV_STORE : OP_NONE;
      ST_IDLE:     cmd.op = (in_valid && !cfg_hit) ? OP_ACCEPT : OP_NONE;
      ST_READ:     cmd.op = OP_READ;
      ST_ACC:      cmd.op = OP_ACC;
      ST_EMIT:     cmd.op = sts.out_free ? OP_EMIT : OP_NONE;
      ST_ADVANCE:  cmd.op = OP_ADVANCE;
      default:     cmd.op = OP_NONE;
    endcase
  end

  assign in_stall = (state_r != ST_IDLE) || cfg_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RESTART;
      sel_r   <= DSEL_DW;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/box_filter_image_downscaler_unit.sv @@
// ----------------------------------------------------------------------------
// box_filter_image_downscaler_unit
// Area-average image downscaler: source pixels in raster order, one RGBA
// destination pixel out per completed box footprint.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   in_source_pixel (0xAARRGGBB)
//   out      output     out_valid/out_stall red, green, blue, alpha, x, y, last
//   cfg      input      cfg_write_enable    cfg_index, cfg_write_data
//
// One pixel at a time. Each pixel runs four bound divisions (x0, x1, y0, y1)
// through the single shared bit-serial divider; one that closes a footprint
// runs four more divisions for the channel means.
// After reset and after a write within the register list the column sum
// memory is swept clear, all 4096 entries, plus two divisions when the
// destination size must be scaled down; no transaction is taken in that time.
// A stalled result holds only the sequencer in its emit step; the output
// register parts the two sides.
// ----------------------------------------------------------------------------
`default_nettype none

module box_filter_image_downscaler_unit
  import bfid_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_write_enable,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_write_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [31:0]          in_source_pixel,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic      [7:0]           out_red,
  output logic      [7:0]           out_green,
  output logic      [7:0]           out_blue,
  output logic      [7:0]           out_alpha,
  output logic      [COL_W-1:0]     out_dest_x,
  output logic      [COL_W-1:0]     out_dest_y,
  output logic                      out_frame_last
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    cfg_hit;

  // writes past the register list change nothing and do not restart
  assign cfg_hit = cfg_write_enable &&
                   ((cfg_index == REG_SRC_W) || (cfg_index == REG_SRC_H) ||
                    (cfg_index == REG_MAX_DIM));

  bfid_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_hit  (cfg_hit),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bfid_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_write_data   (cfg_write_data),
    .in_source_pixel  (in_source_pixel),
    .cmd              (cmd),
    .sts              (sts),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_alpha        (out_alpha),
    .out_dest_x       (out_dest_x),
    .out_dest_y       (out_dest_y),
    .out_frame_last   (out_frame_last)
  );

  // a taken transaction closes the input until the pixel is done
  a_accept_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input open straight after a transaction");

  // emit only into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_EMIT) |-> sts.out_free)
    else $error("result emitted over a pending one");

  // an emit always shows a result next cycle
  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_EMIT) |=> out_valid)
    else $error("emitted result not presented");

endmodule

`default_nettype wire
